@@ hw/rtl/mbp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// MSB-first bit packer package
// Shared widths, defaults and the word types passed between the packer stages.
// ----------------------------------------------------------------------------
package mbp_pkg;

    localparam int MBP_VAL_W    = 64;
    localparam int MBP_NBITS_W  = 7;
    localparam int MBP_BYTE_W   = 8;
    localparam int MBP_CNT_W    = 3;
    localparam int MBP_MAX_BITS = 64;
    localparam int MBP_CQ_DEPTH = 2;
    localparam int MBP_OQ_DEPTH = 2;

    typedef enum logic
    {
        MBP_CMD_APPEND = 1'b0,
        MBP_CMD_FLUSH  = 1'b1
    } mbp_op_t;

    typedef struct packed
    {
        logic                   flush;
        logic [MBP_VAL_W-1:0]   val_al;
        logic [MBP_NBITS_W-1:0] nbits;
    } mbp_cmd_t;

    typedef struct packed
    {
        logic [MBP_BYTE_W-1:0] out_byte;
        logic                  last;
    } mbp_res_t;

endpackage : mbp_pkg
`default_nettype wire

@@ hw/rtl/msb_first_bit_packer_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// MSB-first bit packer
// Packs variable-length bit fields, most significant bit first, into bytes.
//
// Input side is a queue: a word (cmd, value, nbits) is taken on a rising edge
// with push high and full low. cmd append adds the low nbits bits of value
// (nbits above MAX_BITS saturates); cmd flush pads any residue with zeros.
// Result side is a queue: while empty is low, out_byte/last show the oldest
// byte, taken on a rising edge with pop high; last marks an input's final byte.
// A word passes the front stage register, the word queue, the back-end
// shift register and the output queue. The back end emits one byte per cycle
// while the output queue is not full; a word completes up to 8 bytes, and the
// next word is loaded in the cycle its predecessor's final byte leaves.
// Reset clears the residue and both queues. When pop stays low the output
// queue fills, the back end holds, then the word queue and front stage fill
// and full rises; nothing is dropped.
// ----------------------------------------------------------------------------
module msb_first_bit_packer_top #(
    parameter int MAX_BITS = mbp_pkg::MBP_MAX_BITS,
    parameter int CQ_DEPTH = mbp_pkg::MBP_CQ_DEPTH,
    parameter int OQ_DEPTH = mbp_pkg::MBP_OQ_DEPTH
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             push,
    output logic                                  full,
    input  wire logic                             cmd,
    input  wire logic [mbp_pkg::MBP_VAL_W-1:0]    value,
    input  wire logic [mbp_pkg::MBP_NBITS_W-1:0]  nbits,
    output logic                                  empty,
    input  wire logic                             pop,
    output logic [mbp_pkg::MBP_BYTE_W-1:0]        out_byte,
    output logic                                  last
);

    import mbp_pkg::*;

    mbp_cmd_t fr_item;
    logic     fr_push;
    logic     cq_full;
    mbp_cmd_t cq_item;
    logic     cq_empty;
    logic     cq_pop;
    mbp_res_t bk_item;
    logic     bk_push;
    logic     oq_full;
    mbp_res_t oq_item;

    mbp_front #(
        .MAX_BITS (MAX_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .cmd     (cmd),
        .value   (value),
        .nbits   (nbits),
        .cq_item (fr_item),
        .cq_push (fr_push),
        .cq_full (cq_full)
    );

    mbp_fifo #(
        .WIDTH ($bits(mbp_cmd_t)),
        .DEPTH (CQ_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fr_push),
        .wdata (fr_item),
        .full  (cq_full),
        .pop   (cq_pop),
        .rdata (cq_item),
        .empty (cq_empty)
    );

    mbp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cq_item  (cq_item),
        .cq_empty (cq_empty),
        .cq_pop   (cq_pop),
        .oq_item  (bk_item),
        .oq_push  (bk_push),
        .oq_full  (oq_full)
    );

    mbp_fifo #(
        .WIDTH ($bits(mbp_res_t)),
        .DEPTH (OQ_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (bk_push),
        .wdata (bk_item),
        .full  (oq_full),
        .pop   (pop),
        .rdata (oq_item),
        .empty (empty)
    );

    assign out_byte = oq_item.out_byte;
    assign last     = oq_item.last;

endmodule : msb_first_bit_packer_top
`default_nettype wire

@@ hw/rtl/mbp_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Packer word and byte queue
// Small first-in first-out queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module mbp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == CW'(DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count failed to advance");

endmodule : mbp_fifo
`default_nettype wire

@@ hw/rtl/mbp_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Packer front end
// Accepts input words, saturates the bit count and left-aligns the value bits.
// ----------------------------------------------------------------------------
module mbp_front #(
    parameter int MAX_BITS = mbp_pkg::MBP_MAX_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic                            cmd,
    input  wire logic [mbp_pkg::MBP_VAL_W-1:0]   value,
    input  wire logic [mbp_pkg::MBP_NBITS_W-1:0] nbits,
    output mbp_pkg::mbp_cmd_t                    cq_item,
    output logic                                 cq_push,
    input  wire logic                            cq_full
);

    import mbp_pkg::*;

    logic                   vld_reg;
    logic                   vld_next;
    mbp_cmd_t               item_reg;
    mbp_cmd_t               item_next;
    logic                   accept;
    logic [MBP_NBITS_W-1:0] n_sat;

    assign full    = vld_reg && cq_full;
    assign accept  = push && !full;
    assign cq_push = vld_reg && !cq_full;
    assign cq_item = item_reg;

    always_comb
    begin
        n_sat = (nbits > MBP_NBITS_W'(MAX_BITS)) ? MBP_NBITS_W'(MAX_BITS) : nbits;
        item_next.flush  = (mbp_op_t'(cmd) == MBP_CMD_FLUSH);
        item_next.nbits  = item_next.flush ? '0 : n_sat;
        item_next.val_al = item_next.flush ? '0
                         : (value << (MBP_NBITS_W'(MBP_VAL_W) - n_sat));
        vld_next = accept || (vld_reg && cq_full);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg && cq_full) |=> (vld_reg && item_reg == $past(item_reg)))
        else $error("front word lost while queue full");

    a_nbits_sat: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg |-> (item_reg.nbits <= MBP_NBITS_W'(MAX_BITS)))
        else $error("front bit count not saturated");

    a_flush_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg && item_reg.flush) |-> (item_reg.nbits == '0))
        else $error("flush word carries bit count");

endmodule : mbp_front
`default_nettype wire

@@ hw/rtl/mbp_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Packer back end
// Merges words with the residue; emits one byte per cycle unless oq_full.
// ----------------------------------------------------------------------------
module mbp_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mbp_pkg::mbp_cmd_t cq_item,
    input  wire logic              cq_empty,
    output logic                   cq_pop,
    output mbp_pkg::mbp_res_t      oq_item,
    output logic                   oq_push,
    input  wire logic              oq_full
);

    import mbp_pkg::*;

    localparam int SH_W   = MBP_VAL_W + MBP_BYTE_W;
    localparam int LEFT_W = 4;

    logic [SH_W-1:0]        sh_reg;
    logic [SH_W-1:0]        sh_next;
    logic [LEFT_W-1:0]      left_reg;
    logic [LEFT_W-1:0]      left_next;
    logic [MBP_CNT_W-1:0]   cnt_reg;
    logic [MBP_CNT_W-1:0]   cnt_next;
    logic                   busy;
    logic                   emit;
    logic                   load;
    logic [SH_W-1:0]        shifted;
    logic [MBP_BYTE_W-1:0]  acc_cur;
    logic [MBP_NBITS_W-1:0] total;

    assign busy    = (left_reg != '0);
    assign emit    = busy && !oq_full;
    assign oq_push = emit;
    assign shifted = sh_reg << MBP_BYTE_W;
    assign load    = !cq_empty && (!busy || (left_reg == LEFT_W'(1) && emit));
    assign cq_pop  = load;

    always_comb
    begin
        oq_item.out_byte = sh_reg[SH_W-1 -: MBP_BYTE_W];
        oq_item.last     = (left_reg == LEFT_W'(1));
        acc_cur = emit ? shifted[SH_W-1 -: MBP_BYTE_W] : sh_reg[SH_W-1 -: MBP_BYTE_W];
        total   = MBP_NBITS_W'(cnt_reg) + cq_item.nbits;
        sh_next   = sh_reg;
        left_next = left_reg;
        cnt_next  = cnt_reg;
        if (load)
        begin
            if (cq_item.flush)
            begin
                sh_next   = {acc_cur, {MBP_VAL_W{1'b0}}};
                left_next = (cnt_reg != '0) ? LEFT_W'(1) : '0;
                cnt_next  = '0;
            end
            else
            begin
                sh_next   = {acc_cur, {MBP_VAL_W{1'b0}}}
                          | ({cq_item.val_al, {MBP_BYTE_W{1'b0}}} >> cnt_reg);
                left_next = total[MBP_NBITS_W-1:MBP_CNT_W];
                cnt_next  = total[MBP_CNT_W-1:0];
            end
        end
        else if (emit)
        begin
            sh_next   = shifted;
            left_next = left_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sh_reg   <= '0;
            left_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            sh_reg   <= sh_next;
            left_reg <= left_next;
            cnt_reg  <= cnt_next;
        end
    end

    a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= LEFT_W'(8))
        else $error("byte count beyond eight");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> (sh_reg[MBP_VAL_W-1:0] == '0))
        else $error("stale bits below residue");

    a_residue_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> ((sh_reg[SH_W-1 -: MBP_BYTE_W] << cnt_reg) == '0))
        else $error("residue wider than its count");

    a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (load && cq_item.flush) |=> (cnt_reg == '0))
        else $error("flush left bits pending");

endmodule : mbp_back
`default_nettype wire
